// ----- src/hnbf_pkg.sv -----
`default_nettype none
package hnbf_pkg;

	// Field widths
	localparam int ACTION_W = 2;
	localparam int BYTE_W   = 8;
	localparam int CFG_W    = 4;
	localparam int FCS_W    = 16;
	localparam int ONES_W   = 3;
	localparam int BITCNT_W = $clog2(BYTE_W);

	// Framing constants
	localparam int                 MAX_START_FLAGS_DEF = 8;
	localparam logic [CFG_W-1:0]   FLAG_COUNT_RESET    = 4'd4;
	localparam logic [ONES_W-1:0]  STUFF_LIMIT         = 3'd5;
	localparam logic [BYTE_W-1:0]  FLAG_PATTERN        = 8'h7E;
	localparam logic [FCS_W-1:0]   FCS_INIT            = 16'hFFFF;
	localparam logic [FCS_W-1:0]   FCS_POLY            = 16'h8408;

	// Frame event codes
	typedef enum logic [ACTION_W-1:0] {
		ACT_START = 2'd0,
		ACT_DATA  = 2'd1,
		ACT_END   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Serializer phase
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_FLAG,
		PH_DATA,
		PH_FCS_LO,
		PH_FCS_HI,
		PH_CLOSE
	} phase_t;

	// Control of the bit-serial FCS unit
	typedef struct packed {
		logic init;
		logic step;
		logic din;
	} crc_ctl_t;

endpackage
`default_nettype wire

// ----- src/hnbf_crc.sv -----
`default_nettype none
module hnbf_crc (
	input  wire                          clk,
	input  wire                          arst_n,
	input  hnbf_pkg::crc_ctl_t           ctl,
	output logic [hnbf_pkg::FCS_W-1:0]   crc
);
	import hnbf_pkg::*;

	logic [FCS_W-1:0] crc_q;
	logic             fb;

	// Reflected CRC, one payload bit per step
	assign fb = crc_q[0] ^ ctl.din;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= FCS_INIT;
		end else if (ctl.init) begin
			crc_q <= FCS_INIT;
		end else if (ctl.step) begin
			crc_q <= {1'b0, crc_q[FCS_W-1:1]} ^ (fb ? FCS_POLY : '0);
		end
	end

	assign crc = crc_q;

endmodule
`default_nettype wire

// ----- src/hdlc_nrzi_bit_stuffing_framer_core.sv -----
`default_nettype none
// HDLC framer core: frame events in, NRZI line bits out, one per output item.
// Input channel (in_valid / in_stall, action + data_byte): a start event
// sends the configured number of 0x7E flags, a data event sends the byte
// LSB first with a zero stuffed after five ones, an end event sends the
// complemented CRC-16/X.25 FCS (low byte first, stuffed) and one closing
// flag. Action 3 is taken and dropped.
// Output channel (out_valid / out_stall, line_bit + last_bit): last_bit
// marks the final line bit of an event.
// Config channel (cfg_valid / cfg_ready, start_flag_count): opening flag
// count, 0 acts as 1, values above MAX_START_FLAGS act as MAX_START_FLAGS.
// Timing: one event at a time; a taken event is loaded into the serializer
// shift register and each line bit is registered to the output, one bit
// per cycle while the output is not stalled; an event makes 8 to 10 line
// bits for data, 8 per flag and up to 28 for an end.
// A stalled output holds its bit and freezes the serializer.
// Reset (arst_n low) clears the line level to space, the FCS to 0xFFFF and
// sets the flag count to 4.
module hdlc_nrzi_bit_stuffing_framer_core #(
	parameter int MAX_START_FLAGS = hnbf_pkg::MAX_START_FLAGS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_stall,
	input  wire  [hnbf_pkg::ACTION_W-1:0]   action,
	input  wire  [hnbf_pkg::BYTE_W-1:0]     data_byte,
	output logic                            out_valid,
	input  wire                             out_stall,
	output logic                            line_bit,
	output logic                            last_bit,
	input  wire                             cfg_valid,
	output logic                            cfg_ready,
	input  wire  [hnbf_pkg::CFG_W-1:0]      start_flag_count
);
	import hnbf_pkg::*;

	localparam int FLW = $clog2(MAX_START_FLAGS + 1);

	phase_t              phase_q, phase_d;
	logic [CFG_W-1:0]    flag_cnt_q;
	logic [FLW-1:0]      flags_left_q;
	logic [BYTE_W-1:0]   shift_q;
	logic [BITCNT_W-1:0] bitcnt_q;
	logic                stuff_q, stuff_end_q;
	logic [ONES_W-1:0]   ones_q;
	logic                level_q;
	logic                out_valid_q, line_bit_q, last_q;
	logic [FCS_W-1:0]    crc;
	crc_ctl_t            crc_ctl;

	logic                busy, step, in_acc, stuffable;
	logic                emit_bit, need_stuff, bit_last, seg_end, item_end;
	logic [CFG_W-1:0]    flag_eff;
	logic [BYTE_W-1:0]   seg_next;

	assign busy      = (phase_q != PH_IDLE);
	assign in_stall  = busy;
	assign in_acc    = in_valid && !busy;
	assign cfg_ready = !busy;
	assign step      = busy && (!out_valid_q || !out_stall);

	// Decode the current line bit, segment boundaries, flag count and FCS control
	always_comb begin
		stuffable  = (phase_q inside {PH_DATA, PH_FCS_LO, PH_FCS_HI});
		emit_bit   = stuff_q ? 1'b0 : shift_q[0];
		bit_last   = (bitcnt_q == BITCNT_W'(BYTE_W - 1));
		need_stuff = !stuff_q && stuffable && shift_q[0]
			&& (ones_q == STUFF_LIMIT - ONES_W'(1));
		seg_end    = stuff_q ? stuff_end_q : (bit_last && !need_stuff);
		item_end   = seg_end && ((phase_q == PH_DATA) || (phase_q == PH_CLOSE)
			|| ((phase_q == PH_FLAG) && (flags_left_q == FLW'(1))));
		case (phase_q)
			PH_FCS_LO: seg_next = ~crc[FCS_W-1:BYTE_W];
			default:   seg_next = FLAG_PATTERN;
		endcase
		if (flag_cnt_q == '0) begin
			flag_eff = CFG_W'(1);
		end else if (flag_cnt_q > CFG_W'(MAX_START_FLAGS)) begin
			flag_eff = CFG_W'(MAX_START_FLAGS);
		end else begin
			flag_eff = flag_cnt_q;
		end
		crc_ctl.init = (in_acc && (action == ACT_START))
			|| (step && seg_end && (phase_q == PH_CLOSE));
		crc_ctl.step = step && !stuff_q && (phase_q == PH_DATA);
		crc_ctl.din  = shift_q[0];
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (in_acc) begin
			case (action)
				ACT_START: phase_d = PH_FLAG;
				ACT_DATA:  phase_d = PH_DATA;
				ACT_END:   phase_d = PH_FCS_LO;
				default:   phase_d = PH_IDLE;
			endcase
		end else if (step && seg_end) begin
			case (phase_q)
				PH_FLAG:   phase_d = item_end ? PH_IDLE : PH_FLAG;
				PH_FCS_LO: phase_d = PH_FCS_HI;
				PH_FCS_HI: phase_d = PH_CLOSE;
				default:   phase_d = PH_IDLE;
			endcase
		end
	end

	// Advance control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			flag_cnt_q   <= FLAG_COUNT_RESET;
			flags_left_q <= '0;
			bitcnt_q     <= '0;
			stuff_q      <= 1'b0;
			stuff_end_q  <= 1'b0;
			ones_q       <= '0;
			level_q      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (cfg_valid && cfg_ready) begin
				flag_cnt_q <= start_flag_count;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				bitcnt_q <= '0;
				stuff_q  <= 1'b0;
				if (action == ACT_START) begin
					ones_q       <= '0;
					flags_left_q <= FLW'(flag_eff);
				end
			end else if (step) begin
				level_q     <= level_q ^ ~emit_bit;
				out_valid_q <= 1'b1;
				if (stuff_q) begin
					stuff_q <= 1'b0;
					ones_q  <= '0;
				end else begin
					bitcnt_q <= bitcnt_q + BITCNT_W'(1);
					if (stuffable) begin
						if (!shift_q[0]) begin
							ones_q <= '0;
						end else if (need_stuff) begin
							stuff_q     <= 1'b1;
							stuff_end_q <= bit_last;
							ones_q      <= '0;
						end else begin
							ones_q <= ones_q + ONES_W'(1);
						end
					end
				end
				if (seg_end && ((phase_q == PH_FLAG) || (phase_q == PH_CLOSE))) begin
					ones_q <= '0;
				end
				if (seg_end && (phase_q == PH_FLAG)) begin
					flags_left_q <= flags_left_q - FLW'(1);
				end
			end
		end
	end

	// Load and shift the serializer, hold the output bit
	always_ff @(posedge clk) begin
		if (in_acc) begin
			case (action)
				ACT_DATA: shift_q <= data_byte;
				ACT_END:  shift_q <= ~crc[BYTE_W-1:0];
				default:  shift_q <= FLAG_PATTERN;
			endcase
		end else if (step) begin
			line_bit_q <= level_q ^ ~emit_bit;
			last_q     <= item_end;
			if (seg_end) begin
				shift_q <= seg_next;
			end else if (!stuff_q) begin
				shift_q <= {1'b0, shift_q[BYTE_W-1:1]};
			end
		end
	end

	hnbf_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	assign out_valid = out_valid_q;
	assign line_bit  = line_bit_q;
	assign last_bit  = last_q;

	// A pending stuff bit belongs to a stuffed segment
	a_stuff_phase: assert property (@(posedge clk) disable iff (!arst_n)
		stuff_q |-> (phase_q == PH_DATA || phase_q == PH_FCS_LO || phase_q == PH_FCS_HI))
		else $error("stuff bit pending outside a stuffed segment");

	// The run of ones never reaches the stuffing limit
	a_ones_run: assert property (@(posedge clk) disable iff (!arst_n)
		ones_q < STUFF_LIMIT)
		else $error("ones run reached stuffing limit");

	// A taken frame event starts the serializer
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && action != ACT_NONE) |=> busy)
		else $error("frame event taken but serializer idle");

	// The serializer returns to idle only after emitting a marked bit
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !$past(in_acc) ##1 !busy) |-> (out_valid_q && last_q))
		else $error("serializer went idle without a last bit");

endmodule
`default_nettype wire
